[rtl/core/vaslp_pkg.sv]
// Package for the variable assignment line parser.
// Holds the parse phase and result kind codes, the result struct and the
// character helpers; no dependencies.
package vaslp_pkg;

    typedef enum logic [2:0] {
        PH_KEYWORD = 3'd0,
        PH_NAME    = 3'd1,
        PH_OPENER  = 3'd2,
        PH_CONTENT = 3'd3,
        PH_SEMI    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_NAME    = 3'd1,
        KIND_CONTENT = 3'd2,
        KIND_COMMIT  = 3'd3,
        KIND_ABORT   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [3:0] name_length;
        logic [8:0] content_length;
        logic       is_history;
    } result_t;

    localparam logic [3:0] MAX_NAME_RESET    = 4'd10;
    localparam logic [7:0] MAX_CONTENT_RESET = 8'd250;

    localparam logic [0:0] CFG_MAX_NAME    = 1'b0;
    localparam logic [0:0] CFG_MAX_CONTENT = 1'b1;

    localparam logic [7:0] CH_EQUALS = 8'h3D;  // '='
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] CH_QUOTE  = 8'h22;  // '"'
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
    localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
    localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
    localparam logic [7:0] CH_LOW_H  = 8'h68;  // 'h'

    // keyword "var " one character at a time
    function automatic logic [7:0] keyword_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h76;  // 'v'
            2'd1:    ch = 8'h61;  // 'a'
            2'd2:    ch = 8'h72;  // 'r'
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h30) && (c <= 8'h39));
    endfunction

endpackage

[rtl/core/vaslp_in_reg.sv]
// Input register stage of the line parser.
// Captures one byte per transfer; depends on vaslp_pkg.
module vaslp_in_reg
    import vaslp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_out
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_out   = byte_reg;

endmodule

[rtl/core/vaslp_parse.sv]
// Parser state machine and limit registers of the line parser.
// Decides one result per byte; depends on vaslp_pkg.
module vaslp_parse
    import vaslp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [0:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       fire,
    input  logic [7:0] byte_in,
    output result_t    result
);

    phase_t     phase_reg, phase_next;
    logic [1:0] kw_reg, kw_next;
    logic [3:0] name_cnt_reg, name_cnt_next;
    logic       closed_reg, closed_next;
    logic       first_h_reg, first_h_next;
    logic       bracket_reg, bracket_next;
    logic [7:0] content_cnt_reg, content_cnt_next;
    logic [3:0] max_name_reg;
    logic [7:0] max_content_reg;
    logic       fail;
    logic       clear;
    logic       is_closer;

    assign is_closer = (byte_in == CH_QUOTE && !bracket_reg) ||
                       (byte_in == CH_RBRACK && bracket_reg);

    always_comb begin
        phase_next       = phase_reg;
        kw_next          = kw_reg;
        name_cnt_next    = name_cnt_reg;
        closed_next      = closed_reg;
        first_h_next     = first_h_reg;
        bracket_next     = bracket_reg;
        content_cnt_next = content_cnt_reg;
        fail             = 1'b0;
        clear            = 1'b0;
        result           = '0;
        result.kind      = KIND_NONE;

        unique case (phase_reg)
            PH_KEYWORD: begin
                if (byte_in == keyword_char(kw_reg)) begin
                    kw_next = kw_reg + 2'd1;
                    if (kw_reg == 2'd3) begin
                        phase_next = PH_NAME;
                    end
                end else begin
                    if (kw_reg != 2'd0) begin
                        result.kind = KIND_ABORT;
                    end
                    clear = 1'b1;
                end
            end
            PH_NAME: begin
                if (byte_in == CH_EQUALS) begin
                    phase_next = PH_OPENER;
                end else if (!closed_reg && name_cnt_reg < max_name_reg) begin
                    if (is_alnum(byte_in)) begin
                        if (name_cnt_reg == 4'd0) begin
                            first_h_next = (byte_in == CH_LOW_H);
                        end
                        name_cnt_next    = name_cnt_reg + 4'd1;
                        result.kind      = KIND_NAME;
                        result.data_byte = byte_in;
                    end else if (byte_in == CH_SPACE) begin
                        closed_next = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            PH_OPENER: begin
                if (byte_in == CH_QUOTE || byte_in == CH_LBRACK) begin
                    bracket_next     = (byte_in == CH_LBRACK);
                    content_cnt_next = '0;
                    phase_next       = PH_CONTENT;
                    result.kind      = KIND_CONTENT;
                    result.data_byte = byte_in;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_CONTENT: begin
                if (is_closer) begin
                    phase_next       = PH_SEMI;
                    result.kind      = KIND_CONTENT;
                    result.data_byte = byte_in;
                end else if (content_cnt_reg < max_content_reg) begin
                    content_cnt_next = content_cnt_reg + 8'd1;
                    result.kind      = KIND_CONTENT;
                    result.data_byte = byte_in;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_SEMI: begin
                if (byte_in == CH_SEMI) begin
                    result.kind           = KIND_COMMIT;
                    result.name_length    = name_cnt_reg;
                    result.content_length = {1'b0, content_cnt_reg} + 9'd2;
                    result.is_history     = first_h_reg;
                    clear                 = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end
            default: begin
                fail = 1'b1;
            end
        endcase

        if (fail) begin
            result      = '0;
            result.kind = KIND_ABORT;
            clear       = 1'b1;
        end

        if (clear) begin
            phase_next       = PH_KEYWORD;
            kw_next          = '0;
            name_cnt_next    = '0;
            closed_next      = 1'b0;
            first_h_next     = 1'b0;
            bracket_next     = 1'b0;
            content_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_KEYWORD;
            kw_reg          <= '0;
            name_cnt_reg    <= '0;
            closed_reg      <= 1'b0;
            first_h_reg     <= 1'b0;
            bracket_reg     <= 1'b0;
            content_cnt_reg <= '0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            kw_reg          <= kw_next;
            name_cnt_reg    <= name_cnt_next;
            closed_reg      <= closed_next;
            first_h_reg     <= first_h_next;
            bracket_reg     <= bracket_next;
            content_cnt_reg <= content_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_name_reg    <= MAX_NAME_RESET;
            max_content_reg <= MAX_CONTENT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MAX_NAME:    max_name_reg    <= cfg_wdata[3:0];
                CFG_MAX_CONTENT: max_content_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

endmodule

[rtl/core/vaslp_out_reg.sv]
// Result register stage of the line parser.
// Holds one result until the receiver takes it; depends on vaslp_pkg.
module vaslp_out_reg
    import vaslp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     result,
    output logic        advance,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [2:0]  m_tuser
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign advance = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {2'b00, res_reg.is_history, res_reg.content_length,
                       res_reg.name_length, res_reg.data_byte};

endmodule

[rtl/core/var_assignment_line_parser.sv]
// Variable assignment line parser: recognizes  var NAME="...";  and
// var NAME=[...];  in a byte stream and tags every byte with one result.
//
// Channels: s_ takes one text byte per transfer. m_ gives one result per
// input byte: m_tuser is the kind (none, name byte, content byte, commit,
// abort); m_tdata carries the byte and, on commit, the name length,
// content length (both delimiters counted) and the history flag.
// cfg_we/cfg_addr/cfg_wdata write the name limit (0) and content limit (1);
// write only while the block is idle.
//
// Path: a byte taken on s_ goes into the input register; the parser decision
// on it then goes into the result register, which offers it on m_.
// Throughput: one byte per cycle while the receiver takes results (m_tready);
// the parser state updates once per byte.
// Reset (aresetn low, synchronous) empties both registers, returns the parser
// to keyword search and loads limits 10 and 250.
// Receiver stall: the result register holds; the input register can still take
// one more byte, then s_tready drops until m_tready returns.
module var_assignment_line_parser
    import vaslp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [11:8] name_length,
                                   // [20:12] content_length, [21] is_history
    output logic [2:0]  m_tuser,   // [2:0] kind
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_q;
    logic       fire;
    result_t    result;

    assign fire = byte_valid && advance;

    vaslp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_out   (byte_q)
    );

    vaslp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .byte_in   (byte_q),
        .result    (result)
    );

    vaslp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/vaslp_checker.sv]
// Port-level checks for the variable assignment line parser, plus the bind
// that attaches them to the top level; depends on vaslp_pkg.
module vaslp_checker
    import vaslp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= KIND_ABORT)
        else $error("kind out of range");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_NAME && m_tuser != KIND_CONTENT
        |-> m_tdata[7:0] == 8'd0)
        else $error("data byte set on a non-byte result");

    a_commit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_COMMIT |-> m_tdata[21:8] == 14'd0)
        else $error("lengths or history set without commit");

endmodule

bind var_assignment_line_parser vaslp_checker u_vaslp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
